// ----- rtl/cpwl_pkg.sv -----
// Shared types, constants and codes for the clamped piecewise-linear vector lookup.
`default_nettype none

package cpwl_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam int WEIGHT_W = 32;
    localparam int COMP_W   = 32;
    localparam int LANES    = 3;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;

    // Restoring divider: one quotient bit per step.
    localparam int DIV_STEPS = COMP_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        CLAMP_INTERP = 2'd0,
        CLAMP_BELOW  = 2'd1,
        CLAMP_ABOVE  = 2'd2,
        CLAMP_EXACT  = 2'd3
    } t_clamp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_FIN,
        S_EMIT
    } t_state;

    typedef logic [LANES-1:0][COMP_W-1:0] t_vec;

    typedef struct packed {
        t_vec                vec;
        logic [WEIGHT_W-1:0] weight;
    } t_entry;

    typedef struct packed {
        logic   mem_wr;       // store the incoming entry
        logic   query_latch;  // capture the lookup weight
        logic   rd_en;        // table read into the read register
        logic   prev_load;    // read register becomes the lower bracket
        logic   interp_start; // form span, offset and per-lane deltas
        logic   mul_en;       // delta magnitude times offset
        logic   div_step;     // one quotient bit per lane
        logic   res_load;     // load the result stage
        logic   res_interp;   // result from the divider, else from the read entry
        t_clamp code;
        logic   out_load;     // result stage into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic w_lt; // lookup weight below the entry in the read register
        logic w_eq; // lookup weight equal to it
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/cpwl_dp.sv -----
// Datapath: breakpoint table, bracket registers, multiplier, serial divider, result stages.
`default_nettype none

module cpwl_dp #(
    parameter int TABLE_DEPTH = cpwl_pkg::DEF_TABLE_DEPTH
) (
    input  wire                                 i_clk,
    input  wire cpwl_pkg::t_dp_cmd              i_cmd,
    input  wire [$clog2(TABLE_DEPTH)-1:0]       i_rd_addr,
    input  wire [cpwl_pkg::INDEX_W-1:0]         i_entry_index,
    input  wire cpwl_pkg::t_entry               i_item,
    output cpwl_pkg::t_dp_status                o_status,
    output cpwl_pkg::t_vec                      o_out_vec,
    output cpwl_pkg::t_clamp                    o_out_code
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int W     = cpwl_pkg::COMP_W;
    localparam int L     = cpwl_pkg::LANES;

    cpwl_pkg::t_entry mem [TABLE_DEPTH];

    cpwl_pkg::t_entry                  r_rd;
    cpwl_pkg::t_entry                  r_prev;
    logic [cpwl_pkg::WEIGHT_W-1:0]     r_weight;
    logic [cpwl_pkg::WEIGHT_W-1:0]     r_den;
    logic [cpwl_pkg::WEIGHT_W-1:0]     r_num;
    logic [L-1:0]                      r_neg;
    logic [W-1:0]                      r_lo  [L];
    logic [W-1:0]                      r_mag [L];
    logic [W-1:0]                      r_rem [L];
    logic [W-1:0]                      r_quo [L];
    cpwl_pkg::t_vec                    r_res_vec;
    cpwl_pkg::t_clamp                  r_res_code;
    cpwl_pkg::t_vec                    r_out_vec;
    cpwl_pkg::t_clamp                  r_out_code;

    logic [IDX_W-1:0]   wr_addr;
    logic               wr_ok;
    logic signed [W:0]  diff  [L];
    logic [W-1:0]       mag   [L];
    logic [2*W-1:0]     prod  [L];
    logic [W:0]         trial [L];
    logic [W:0]         tsub  [L];
    logic [L-1:0]       ge;
    cpwl_pkg::t_vec     interp_vec;

    assign wr_addr = IDX_W'(i_entry_index);
    assign wr_ok   = int'(i_entry_index) < TABLE_DEPTH;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && wr_ok) begin
            mem[wr_addr] <= i_item;
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    assign o_status.w_lt = r_weight <  r_rd.weight;
    assign o_status.w_eq = r_weight == r_rd.weight;

    always_comb begin
        for (int k = 0; k < L; k++) begin
            diff[k]  = $signed({r_rd.vec[k][W-1], r_rd.vec[k]})
                     - $signed({r_prev.vec[k][W-1], r_prev.vec[k]});
            mag[k]   = diff[k][W] ? W'(-diff[k]) : diff[k][W-1:0];
            prod[k]  = r_mag[k] * r_num;
            trial[k] = {r_rem[k], r_quo[k][W-1]};
            tsub[k]  = trial[k] - {1'b0, r_den};
            ge[k]    = trial[k] >= {1'b0, r_den};
            interp_vec[k] = r_neg[k] ? (r_lo[k] - r_quo[k]) : (r_lo[k] + r_quo[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_latch) begin
            r_weight <= i_item.weight;
        end
        if (i_cmd.prev_load) begin
            r_prev <= r_rd;
        end
        if (i_cmd.interp_start) begin
            r_den <= r_rd.weight - r_prev.weight;
            r_num <= r_weight - r_prev.weight;
        end
        for (int k = 0; k < L; k++) begin
            if (i_cmd.interp_start) begin
                r_neg[k] <= diff[k][W];
                r_mag[k] <= mag[k];
                r_lo[k]  <= r_prev.vec[k];
            end
            if (i_cmd.mul_en) begin
                // quotient < 2^W since offset < span, so the high half seeds the remainder
                r_rem[k] <= prod[k][2*W-1:W];
                r_quo[k] <= prod[k][W-1:0];
            end else if (i_cmd.div_step) begin
                r_rem[k] <= ge[k] ? tsub[k][W-1:0] : trial[k][W-1:0];
                r_quo[k] <= {r_quo[k][W-2:0], ge[k]};
            end
        end
        if (i_cmd.res_load) begin
            r_res_vec  <= i_cmd.res_interp ? interp_vec : r_rd.vec;
            r_res_code <= i_cmd.code;
        end
        if (i_cmd.out_load) begin
            r_out_vec  <= r_res_vec;
            r_out_code <= r_res_code;
        end
    end

    assign o_out_vec  = r_out_vec;
    assign o_out_code = r_out_code;

endmodule

`default_nettype wire

// ----- rtl/cpwl_ctrl.sv -----
// Controller: query sequencer, entry count register and output valid.
`default_nettype none

module cpwl_ctrl #(
    parameter int TABLE_DEPTH = cpwl_pkg::DEF_TABLE_DEPTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_valid,
    input  wire                                 i_s_cmd,
    output logic                                o_s_ready,
    input  wire                                 i_cfg_valid,
    input  wire [cpwl_pkg::COUNT_W-1:0]         i_cfg_data,
    output logic                                o_cfg_ready,
    output logic                                o_m_valid,
    input  wire                                 i_m_ready,
    input  wire cpwl_pkg::t_dp_status           i_status,
    output cpwl_pkg::t_dp_cmd                   o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_rd_addr
);

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int STEP_W = cpwl_pkg::STEP_W;

    cpwl_pkg::t_state    r_state, n_state;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_last_idx, n_last_idx;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                r_out_valid, n_out_valid;

    logic accept;
    logic out_free;
    logic div_done;

    // Nothing is taken while reset is held.
    assign o_cfg_ready = i_rst_n;
    assign o_s_ready   = i_rst_n && (r_state == cpwl_pkg::S_IDLE);
    assign accept      = i_s_valid && o_s_ready;
    assign out_free    = !r_out_valid || i_m_ready;
    assign div_done    = (r_step == STEP_W'(cpwl_pkg::DIV_STEPS - 1));
    assign o_m_valid   = r_out_valid;

    // A count of zero acts as one; a count past the table saturates.
    always_comb begin
        n_last_idx = r_last_idx;
        if (i_cfg_valid) begin
            if (i_cfg_data == '0) begin
                n_last_idx = '0;
            end else if (int'(i_cfg_data) > TABLE_DEPTH) begin
                n_last_idx = IDX_W'(TABLE_DEPTH - 1);
            end else begin
                n_last_idx = IDX_W'(i_cfg_data - 1'b1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cpwl_pkg::S_IDLE: begin
                if (accept && i_s_cmd == cpwl_pkg::CMD_QUERY) n_state = cpwl_pkg::S_CHK_FIRST;
            end
            cpwl_pkg::S_CHK_FIRST: begin
                n_state = (i_status.w_lt || i_status.w_eq) ? cpwl_pkg::S_EMIT
                                                            : cpwl_pkg::S_CHK_LAST;
            end
            cpwl_pkg::S_CHK_LAST: begin
                n_state = i_status.w_lt ? cpwl_pkg::S_SCAN : cpwl_pkg::S_EMIT;
            end
            cpwl_pkg::S_SCAN: begin
                if (i_status.w_lt) begin
                    n_state = cpwl_pkg::S_MUL;
                end else if (i_status.w_eq) begin
                    n_state = cpwl_pkg::S_EMIT;
                end
            end
            cpwl_pkg::S_MUL:  n_state = cpwl_pkg::S_DIV;
            cpwl_pkg::S_DIV: begin
                if (div_done) n_state = cpwl_pkg::S_FIN;
            end
            cpwl_pkg::S_FIN:  n_state = cpwl_pkg::S_EMIT;
            cpwl_pkg::S_EMIT: begin
                if (out_free) n_state = cpwl_pkg::S_IDLE;
            end
            default: n_state = cpwl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.code  = cpwl_pkg::CLAMP_INTERP;
        o_rd_addr   = '0;
        n_idx       = r_idx;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_m_ready;
        unique case (r_state)
            cpwl_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_s_cmd == cpwl_pkg::CMD_QUERY) begin
                        o_cmd.query_latch = 1'b1;
                        o_cmd.rd_en       = 1'b1;
                    end else begin
                        o_cmd.mem_wr      = 1'b1;
                    end
                end
            end
            cpwl_pkg::S_CHK_FIRST: begin
                if (i_status.w_lt || i_status.w_eq) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.code     = cpwl_pkg::CLAMP_BELOW;
                end else begin
                    o_cmd.prev_load = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_rd_addr       = r_last_idx;
                end
            end
            cpwl_pkg::S_CHK_LAST: begin
                if (!i_status.w_lt) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.code     = cpwl_pkg::CLAMP_ABOVE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = IDX_W'(1);
                    n_idx       = IDX_W'(1);
                end
            end
            cpwl_pkg::S_SCAN: begin
                if (i_status.w_lt) begin
                    o_cmd.interp_start = 1'b1;
                end else if (i_status.w_eq) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.code     = cpwl_pkg::CLAMP_EXACT;
                end else begin
                    o_cmd.prev_load = 1'b1;
                    o_cmd.rd_en     = 1'b1;
                    o_rd_addr       = r_idx + 1'b1;
                    n_idx           = r_idx + 1'b1;
                end
            end
            cpwl_pkg::S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_step       = '0;
            end
            cpwl_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
            end
            cpwl_pkg::S_FIN: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_interp = 1'b1;
                o_cmd.code       = cpwl_pkg::CLAMP_INTERP;
            end
            cpwl_pkg::S_EMIT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cpwl_pkg::S_IDLE;
            r_idx       <= '0;
            r_last_idx  <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_last_idx  <= n_last_idx;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/clamped_piecewise_linear_vector_lookup.sv -----
// On acceptance a write is stored; a query is clamped below or above, matches entry i exactly
//   or is interpolated between entries i-1 and i (scan, multiply, 32 divide steps).
// Throughput: one query at a time; its table walk reads one entry a cycle and three lane
//   dividers run side by side. A result still waiting on m_tready holds the next query at
//   its final step.
// Reset (synchronous, active low) clears the sequencer and output valid and sets the entry
//   count to one; table contents stay undefined until written.
`default_nettype none

module clamped_piecewise_linear_vector_lookup #(
    parameter int TABLE_DEPTH = cpwl_pkg::DEF_TABLE_DEPTH
) (
    input  wire          i_clk,
    input  wire          i_rst_n,

    // Item input
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [135:0]  s_tdata,  // entry_index[3:0], weight[35:4], vec_x[67:36],
                                   // vec_y[99:68], vec_z[131:100], zero pad [135:132]
    input  wire [0:0]    s_tuser,  // cmd: 0 write entry, 1 query

    // Result output
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [95:0]  m_tdata,  // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [1:0]   m_tuser,  // clamp_code

    // Entry count register
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire [4:0]    i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    cpwl_pkg::t_dp_cmd    dp_cmd;
    cpwl_pkg::t_dp_status dp_status;
    cpwl_pkg::t_entry     item;
    cpwl_pkg::t_vec       out_vec;
    cpwl_pkg::t_clamp     out_code;
    logic [IDX_W-1:0]     rd_addr;

    // Unpack the incoming item; the weight field doubles as the lookup key on queries.
    assign item.weight = s_tdata[35:4];
    assign item.vec[0] = s_tdata[67:36];
    assign item.vec[1] = s_tdata[99:68];
    assign item.vec[2] = s_tdata[131:100];

    cpwl_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_tvalid),
        .i_s_cmd     (s_tuser[0]),
        .o_s_ready   (s_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_m_valid   (m_tvalid),
        .i_m_ready   (m_tready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd),
        .o_rd_addr   (rd_addr)
    );

    cpwl_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (dp_cmd),
        .i_rd_addr     (rd_addr),
        .i_entry_index (s_tdata[3:0]),
        .i_item        (item),
        .o_status      (dp_status),
        .o_out_vec     (out_vec),
        .o_out_code    (out_code)
    );

    // The output register sits in the datapath, so a new item is taken while a result waits.
    assign m_tdata = out_vec;
    assign m_tuser = out_code;

endmodule

`default_nettype wire
